@@ rtl/core/fts_pkg.sv @@
// fts_pkg: shared types and constants of the fifo thread scheduler
// no dependencies; imported by the ring, the top level and the checker

package fts_pkg;

  localparam int THREAD_COUNT = 64;
  localparam int TID_W        = 6;
  localparam int CMD_W        = 3;
  localparam int ST_W         = 2;
  localparam int CNT_W        = $clog2(THREAD_COUNT + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_START    = 3'd0,
    CMD_READY    = 3'd1,
    CMD_PREEMPT  = 3'd2,
    CMD_WAIT     = 3'd3,
    CMD_SCHEDULE = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    TS_UNUSED  = 2'd0,
    TS_READY   = 2'd1,
    TS_RUNNING = 2'd2,
    TS_WAITING = 2'd3
  } tstate_t;

  // requests from the control logic to the ready ring
  typedef struct packed {
    logic             rd_head;
    logic             push;
    logic             pop;
    logic [TID_W-1:0] push_tid;
  } ring_req_t;

  // ring status back to the control logic
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [TID_W-1:0] head_tid;
  } ring_sts_t;

endpackage

@@ rtl/core/fifo_thread_scheduler_core.sv @@
// fifo_thread_scheduler_core: top level of the fifo thread scheduler
// depends on fts_pkg, fts_ram and fts_ring

// Keeps a 2-bit state (unused, ready, running, waiting) for each of 64
// threads in a small memory and a first-in first-out ready queue of thread
// ids in a ring memory. Each accepted item is one event (start, ready,
// preempt, wait, schedule) and gives exactly one result item: status 0 when
// the event applied, 1 when it was rejected, plus the popped thread on a
// successful schedule. An item is accepted in the idle state, which reads
// the thread state and the queue head from the memories (registered read),
// and completes in the exec state, which checks, writes back and loads the
// result register once it is free. A new item is taken only after the
// previous one completes, while its result may still wait on the output.
// The thread states read as unused after reset through per-thread valid
// flags, so no clearing pass is needed.

module fifo_thread_scheduler_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fts_pkg::CMD_W-1:0]  in_command,
  input  logic [fts_pkg::TID_W-1:0]  in_thread_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_status,
  output logic [fts_pkg::TID_W-1:0]  out_next_thread,
  output logic                       out_next_valid
);
  import fts_pkg::*;

  // one-hot sequencer: idle takes an item, exec does the read-modify-write
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } seq_t;

  seq_t              state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [TID_W-1:0]  tid_r;
  logic              accept;
  logic              go;

  // thread state memory and its written flags
  logic [THREAD_COUNT-1:0] written_r, written_nxt;
  logic                    st_we;
  logic [TID_W-1:0]        st_waddr;
  tstate_t                 st_wdata;
  logic [ST_W-1:0]         st_rdata;
  tstate_t                 cur_st;

  ring_req_t ring_req;
  ring_sts_t ring_sts;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r;
  logic [TID_W-1:0] out_next_thread_r;
  logic             out_next_valid_r;
  logic             res_status;
  logic [TID_W-1:0] res_thread;
  logic             res_valid;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // the result register must be free before an item completes
  assign go       = (state_r == S_EXEC) && !(out_valid_r && out_stall);

  fts_ram #(
    .WIDTH(ST_W),
    .DEPTH(THREAD_COUNT)
  ) u_state_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .re   (accept),
    .raddr(in_thread_id),
    .rdata(st_rdata)
  );

  fts_ring u_ring (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ring_req),
    .sts  (ring_sts)
  );

  // a never-written entry reads as unused
  assign cur_st = written_r[tid_r] ? tstate_t'(st_rdata) : TS_UNUSED;

  // event decode; memory writes only happen on the completing cycle, and
  // the next read comes in a later cycle from idle, so no forwarding is required
  always_comb begin
    res_status        = 1'b1;
    res_thread        = '0;
    res_valid         = 1'b0;
    st_we             = 1'b0;
    st_waddr          = tid_r;
    st_wdata          = TS_UNUSED;
    ring_req.rd_head  = accept;
    ring_req.push     = 1'b0;
    ring_req.pop      = 1'b0;
    ring_req.push_tid = tid_r;
    case (cmd_r)
      CMD_START: begin
        if (cur_st == TS_UNUSED) begin
          st_we      = go;
          st_wdata   = TS_WAITING;
          res_status = 1'b0;
        end
      end
      CMD_READY: begin
        if (cur_st == TS_WAITING && !ring_sts.full) begin
          st_we         = go;
          st_wdata      = TS_READY;
          ring_req.push = go;
          res_status    = 1'b0;
        end
      end
      CMD_PREEMPT: begin
        if (cur_st == TS_RUNNING && !ring_sts.full) begin
          st_we         = go;
          st_wdata      = TS_READY;
          ring_req.push = go;
          res_status    = 1'b0;
        end
      end
      CMD_WAIT: begin
        if (cur_st == TS_RUNNING) begin
          st_we      = go;
          st_wdata   = TS_WAITING;
          res_status = 1'b0;
        end
      end
      CMD_SCHEDULE: begin
        // queue head was read at accept time
        if (!ring_sts.empty) begin
          st_we        = go;
          st_waddr     = ring_sts.head_tid;
          st_wdata     = TS_RUNNING;
          ring_req.pop = go;
          res_status   = 1'b0;
          res_thread   = ring_sts.head_tid;
          res_valid    = 1'b1;
        end
      end
      default: begin
        // unknown command: rejected, nothing changes
        res_status = 1'b1;
      end
    endcase
  end

  always_comb begin
    written_nxt = written_r;
    if (st_we) begin
      written_nxt[st_waddr] = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      written_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      written_r   <= written_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      tid_r <= in_thread_id;
    end
    if (go) begin
      out_status_r      <= res_status;
      out_next_thread_r <= res_thread;
      out_next_valid_r  <= res_valid;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_next_thread = out_next_thread_r;
  assign out_next_valid  = out_next_valid_r;

endmodule

@@ rtl/core/fts_ram.sv @@
// fts_ram: generic single write, single read memory with registered read
// no dependencies

module fts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/fts_ring.sv @@
// fts_ring: ready queue as a ring store with head, tail and fill count
// depends on fts_pkg and fts_ram

module fts_ring (
  input  logic              clk,
  input  logic              rst_n,
  input  fts_pkg::ring_req_t req,
  output fts_pkg::ring_sts_t sts
);
  import fts_pkg::*;

  logic [TID_W-1:0] head_r, head_nxt;
  logic [TID_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TID_W-1:0] rdata;

  fts_ram #(
    .WIDTH(TID_W),
    .DEPTH(THREAD_COUNT)
  ) u_ring_ram (
    .clk  (clk),
    .we   (req.push),
    .waddr(tail_r),
    .wdata(req.push_tid),
    .re   (req.rd_head),
    .raddr(head_r),
    .rdata(rdata)
  );

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (req.push) begin
      tail_nxt  = tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (req.pop) begin
      head_nxt  = head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r >= CNT_W'(THREAD_COUNT));
  assign sts.head_tid = rdata;

endmodule

@@ rtl/core/fts_checker.sv @@
// fts_checker: port-level assertions for the fifo thread scheduler
// depends on fts_pkg; bound to fifo_thread_scheduler_core

module fts_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_status,
  input logic [fts_pkg::TID_W-1:0]  out_next_thread,
  input logic                       out_next_valid
);
  import fts_pkg::*;

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_next_thread) && $stable(out_next_valid))
    else $error("result changed while stalled");

  // a popped thread always comes with an applied status
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_next_valid |-> !out_status)
    else $error("popped thread flagged as rejected");

  // no thread id without a pop
  a_no_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_next_valid |-> out_next_thread == '0)
    else $error("thread id given without a pop");

  // reset empties the result register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind fifo_thread_scheduler_core fts_checker u_fts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_next_thread(out_next_thread),
  .out_next_valid (out_next_valid)
);
